@@ hw/rtl/ppr_pkg.sv @@
// Package for the per-port packet reorder buffer.
// Holds field widths, operation and status codes, sequencer states and the
// request and result item types. Depends on nothing.
package ppr_pkg;

	localparam int PORT_W   = 4;
	localparam int NUM_W    = 31;
	localparam int HANDLE_W = 16;
	localparam int BYTES_W  = 13;

	// Stream byte counts saturate at the largest value the field holds.
	localparam logic [BYTES_W-1:0] BYTES_MAX = 13'h1FFF;

	typedef enum logic {
		OP_RECEIVE = 1'b0,
		OP_DRAIN   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STAT_ACCEPTED = 3'd0,
		STAT_STALE    = 3'd1,
		STAT_DUP      = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_STREAM   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_PORT,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t                 op;
		logic [PORT_W-1:0]   port;
		logic [NUM_W-1:0]    packet_num;
		logic [HANDLE_W-1:0] payload_handle;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		logic [PORT_W-1:0]   out_port;
		logic [NUM_W-1:0]    out_packet_num;
		logic [HANDLE_W-1:0] out_handle;
		logic                item_valid;
		logic                last;
		logic [BYTES_W-1:0]  stream_bytes;
	} out_item_t;

endpackage

@@ hw/rtl/ppr_if.sv @@
// Valid/ready channel interfaces for the reorder buffer's request and
// result transactions. Depends on ppr_pkg for the payload types.
interface ppr_req_if;
	logic               valid;
	logic               ready;
	ppr_pkg::in_item_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ppr_rsp_if;
	logic               valid;
	logic               ready;
	ppr_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/ppr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ppr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/ppr_out_buf.sv @@
// One-entry output register between the sequencer and the result channel.
// Depends on ppr_pkg and the ppr_rsp_if interface.
module ppr_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  ppr_pkg::out_item_t push_data,
	ppr_rsp_if.source          rsp
);

	logic               full_q;
	ppr_pkg::out_item_t data_q;

	// A new result may enter in the same cycle the held one leaves.
	assign push_ready = !full_q || rsp.ready;
	assign rsp.valid  = full_q;
	assign rsp.data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push_valid && push_ready) begin
			full_q <= 1'b1;
		end else if (rsp.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			data_q <= push_data;
		end
	end

endmodule

@@ hw/rtl/ppr_engine.sv @@
// Sequencer of the reorder buffer: reads a port's state row, scans the port's
// slots in the slot memory, decides, writes back and hands results onward.
// Depends on ppr_pkg and the ppr_req_if interface; drives two ppr_ram instances.
module ppr_engine #(
	parameter int NUM_PORTS      = 16,
	parameter int SLOTS_PER_PORT = 16,
	parameter int PACKET_BYTES   = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	ppr_req_if.sink                                req,
	// Port state memory: {valid mask, delivered flag, last delivered number}.
	output logic                                   pm_we,
	output logic [$clog2(NUM_PORTS)-1:0]           pm_waddr,
	output logic [SLOTS_PER_PORT+ppr_pkg::NUM_W:0] pm_wdata,
	output logic [$clog2(NUM_PORTS)-1:0]           pm_raddr,
	input  logic [SLOTS_PER_PORT+ppr_pkg::NUM_W:0] pm_rdata,
	// Slot memory: {packet number, payload handle}, one row per port and slot.
	output logic                                   sm_we,
	output logic [$clog2(NUM_PORTS)+((SLOTS_PER_PORT > 1) ?
		$clog2(SLOTS_PER_PORT) : 1)-1:0]           sm_waddr,
	output logic [ppr_pkg::NUM_W+ppr_pkg::HANDLE_W-1:0] sm_wdata,
	output logic [$clog2(NUM_PORTS)+((SLOTS_PER_PORT > 1) ?
		$clog2(SLOTS_PER_PORT) : 1)-1:0]           sm_raddr,
	input  logic [ppr_pkg::NUM_W+ppr_pkg::HANDLE_W-1:0] sm_rdata,
	output logic                                   push_valid,
	input  logic                                   push_ready,
	output ppr_pkg::out_item_t                     push_data
);

	localparam int PORT_AW  = $clog2(NUM_PORTS);
	localparam int SLOT_AW  = (SLOTS_PER_PORT > 1) ? $clog2(SLOTS_PER_PORT) : 1;
	localparam int CNT_W    = $clog2(SLOTS_PER_PORT + 1);
	localparam int NUM_W    = ppr_pkg::NUM_W;
	localparam int HANDLE_W = ppr_pkg::HANDLE_W;
	localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SLOTS_PER_PORT - 1);

	ppr_pkg::state_t state_q, state_d;

	ppr_pkg::op_t                  op_q;
	logic [ppr_pkg::PORT_W-1:0]    port_q;
	logic [PORT_AW-1:0]            pidx_q;
	logic                          in_range_q;
	logic [NUM_W-1:0]              num_q;
	logic [HANDLE_W-1:0]           handle_q;

	logic [SLOTS_PER_PORT-1:0]     mask_q;
	logic                          has_del_q;
	logic [NUM_W-1:0]              last_del_q;

	logic [SLOT_AW-1:0]            scan_idx_q;
	logic                          rd_valid_s1;
	logic [SLOT_AW-1:0]            rd_idx_s1;

	logic                          dup_q;
	logic                          best_found_q;
	logic [NUM_W-1:0]              best_num_q;
	logic [HANDLE_W-1:0]           best_handle_q;
	logic [SLOT_AW-1:0]            best_idx_q;

	logic [CNT_W-1:0]              remain_q;
	logic [ppr_pkg::BYTES_W-1:0]   bytes_q;
	ppr_pkg::out_item_t            res_q;

	logic                          row_valid_q [NUM_PORTS];

	logic                          row_ok;
	logic [SLOTS_PER_PORT-1:0]     rd_mask;
	logic                          rd_has;
	logic [NUM_W-1:0]              rd_last;
	logic                          stale;
	logic [CNT_W-1:0]              held_rd;
	logic [31:0]                   prod;
	logic [ppr_pkg::BYTES_W-1:0]   bytes_rd;
	logic [NUM_W-1:0]              sm_num;
	logic [HANDLE_W-1:0]           sm_handle;
	logic [SLOT_AW-1:0]            free_idx;
	logic                          mask_full;
	logic [SLOTS_PER_PORT-1:0]     mask_set;
	logic [SLOTS_PER_PORT-1:0]     mask_cleared;
	logic                          is_last;
	logic                          accept_ok;

	// A port row never written reads as empty with nothing delivered.
	assign row_ok   = row_valid_q[pidx_q];
	assign rd_mask  = row_ok ? pm_rdata[SLOTS_PER_PORT+NUM_W:NUM_W+1] : '0;
	assign rd_has   = row_ok & pm_rdata[NUM_W];
	assign rd_last  = pm_rdata[NUM_W-1:0];
	assign stale    = rd_has && (num_q <= rd_last);
	assign held_rd  = CNT_W'($countones(rd_mask));
	assign prod     = 32'(held_rd) * 32'(PACKET_BYTES);
	assign bytes_rd = (prod > 32'(ppr_pkg::BYTES_MAX)) ? ppr_pkg::BYTES_MAX :
		ppr_pkg::BYTES_W'(prod);

	assign sm_num    = sm_rdata[NUM_W+HANDLE_W-1:HANDLE_W];
	assign sm_handle = sm_rdata[HANDLE_W-1:0];

	always_comb begin
		free_idx = '0;
		for (int i = SLOTS_PER_PORT - 1; i >= 0; i--) begin
			if (!mask_q[i]) begin
				free_idx = SLOT_AW'(i);
			end
		end
	end

	assign mask_full    = &mask_q;
	assign mask_set     = mask_q | (SLOTS_PER_PORT'(1) << free_idx);
	assign mask_cleared = mask_q & ~(SLOTS_PER_PORT'(1) << best_idx_q);
	assign is_last      = (remain_q == CNT_W'(1));
	assign accept_ok    = !dup_q && !mask_full;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppr_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = ppr_pkg::ST_RD_PORT;
				end
			end
			ppr_pkg::ST_RD_PORT: begin
				priority if (!in_range_q) begin
					state_d = ppr_pkg::ST_EMIT;
				end else if (op_q == ppr_pkg::OP_RECEIVE) begin
					state_d = stale ? ppr_pkg::ST_EMIT : ppr_pkg::ST_SCAN;
				end else begin
					state_d = (held_rd == '0) ? ppr_pkg::ST_EMIT : ppr_pkg::ST_SCAN;
				end
			end
			ppr_pkg::ST_SCAN: begin
				if (scan_idx_q == LAST_SLOT) begin
					state_d = ppr_pkg::ST_SCAN_END;
				end
			end
			ppr_pkg::ST_SCAN_END: state_d = ppr_pkg::ST_DECIDE;
			ppr_pkg::ST_DECIDE:   state_d = ppr_pkg::ST_EMIT;
			ppr_pkg::ST_EMIT: begin
				if (push_ready) begin
					state_d = res_q.last ? ppr_pkg::ST_IDLE : ppr_pkg::ST_SCAN;
				end
			end
			default: state_d = ppr_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		req.ready  = (state_q == ppr_pkg::ST_IDLE);
		push_valid = (state_q == ppr_pkg::ST_EMIT);
		push_data  = res_q;
		pm_raddr   = PORT_AW'(req.data.port);
		pm_waddr   = pidx_q;
		sm_raddr   = {pidx_q, scan_idx_q};
		sm_waddr   = {pidx_q, free_idx};
		sm_wdata   = {num_q, handle_q};
		pm_we      = 1'b0;
		sm_we      = 1'b0;
		pm_wdata   = {mask_set, has_del_q, last_del_q};
		if (state_q == ppr_pkg::ST_DECIDE) begin
			if (op_q == ppr_pkg::OP_RECEIVE) begin
				pm_we = accept_ok;
				sm_we = accept_ok;
			end else begin
				// The drain writes the row back once, after its final packet.
				pm_we    = is_last;
				pm_wdata = {mask_cleared, 1'b1, best_num_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppr_pkg::ST_IDLE;
			rd_valid_s1 <= 1'b0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				row_valid_q[i] <= 1'b0;
			end
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == ppr_pkg::ST_SCAN);
			if (pm_we) begin
				row_valid_q[pidx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;

		if (rd_valid_s1 && mask_q[rd_idx_s1]) begin
			if (op_q == ppr_pkg::OP_RECEIVE) begin
				if (sm_num == num_q) begin
					dup_q <= 1'b1;
				end
			end else if (!best_found_q || sm_num < best_num_q) begin
				best_found_q  <= 1'b1;
				best_num_q    <= sm_num;
				best_handle_q <= sm_handle;
				best_idx_q    <= rd_idx_s1;
			end
		end

		unique case (state_q)
			ppr_pkg::ST_IDLE: begin
				if (req.valid) begin
					op_q       <= req.data.op;
					port_q     <= req.data.port;
					pidx_q     <= PORT_AW'(req.data.port);
					in_range_q <= (32'(req.data.port) < 32'(NUM_PORTS));
					num_q      <= req.data.packet_num;
					handle_q   <= req.data.payload_handle;
				end
			end
			ppr_pkg::ST_RD_PORT: begin
				mask_q       <= rd_mask;
				has_del_q    <= rd_has;
				last_del_q   <= rd_last;
				remain_q     <= held_rd;
				bytes_q      <= bytes_rd;
				dup_q        <= 1'b0;
				best_found_q <= 1'b0;
				scan_idx_q   <= '0;
				res_q        <= '{
					status:         (op_q == ppr_pkg::OP_DRAIN) ? ppr_pkg::STAT_STREAM :
						(in_range_q ? ppr_pkg::STAT_STALE : ppr_pkg::STAT_FULL),
					out_port:       port_q,
					out_packet_num: '0,
					out_handle:     '0,
					item_valid:     1'b0,
					last:           1'b1,
					stream_bytes:   '0
				};
			end
			ppr_pkg::ST_SCAN: begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			ppr_pkg::ST_SCAN_END: begin
			end
			ppr_pkg::ST_DECIDE: begin
				if (op_q == ppr_pkg::OP_RECEIVE) begin
					priority if (dup_q) begin
						res_q.status <= ppr_pkg::STAT_DUP;
					end else if (mask_full) begin
						res_q.status <= ppr_pkg::STAT_FULL;
					end else begin
						res_q.status <= ppr_pkg::STAT_ACCEPTED;
						mask_q       <= mask_set;
					end
				end else begin
					res_q <= '{
						status:         ppr_pkg::STAT_STREAM,
						out_port:       port_q,
						out_packet_num: best_num_q,
						out_handle:     best_handle_q,
						item_valid:     1'b1,
						last:           is_last,
						stream_bytes:   is_last ? bytes_q : '0
					};
					mask_q     <= mask_cleared;
					has_del_q  <= 1'b1;
					last_del_q <= best_num_q;
					remain_q   <= remain_q - 1'b1;
				end
			end
			ppr_pkg::ST_EMIT: begin
				if (push_ready && !res_q.last) begin
					scan_idx_q   <= '0;
					best_found_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// The slot chosen for a new packet must be free.
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		sm_we |-> !mask_q[free_idx])
		else $error("packet written over a held slot");

	// Every drain step has found a held packet.
	a_drain_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppr_pkg::ST_DECIDE && op_q == ppr_pkg::OP_DRAIN) |-> best_found_q)
		else $error("drain step without a held packet");

	// Delivered numbers rise strictly on every port.
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppr_pkg::ST_DECIDE && op_q == ppr_pkg::OP_DRAIN && has_del_q)
		|-> (best_num_q > last_del_q))
		else $error("drain delivers a number at or below the last delivered one");

	// An accepted transaction always starts with the port state read.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ppr_pkg::ST_RD_PORT))
		else $error("accepted transaction did not start a port read");

endmodule

@@ hw/rtl/per_port_packet_reorder_buffer.sv @@
// Per-port packet reorder buffer: holds out-of-order packets per port and
// delivers each port's held packets in ascending packet-number order.
// Request channel req: op 0 stores a packet (port, packet_num, payload_handle)
// and answers with one status transaction (accepted, stale, duplicate, full).
// op 1 drains the port: one stream transaction per held packet, lowest number
// first, last set on the final one, which also carries the drained byte count.
// An empty drain, or a drain of a port out of range, gives one transaction
// with item_valid low.
// Timing: a request is taken only when the previous one has passed all its
// results to the output register. The length of a store and of each drain
// step is set by the slot scan, which reads one slot of the slot memory per
// cycle; a stale drop skips the scan.
// Reset clears all ports to empty with nothing delivered, at once.
// A stalled result channel holds one result in the output register; the
// sequencer waits with the next result until that register frees.
// Depends on ppr_pkg, ppr_if, ppr_ram, ppr_out_buf and ppr_engine.
module per_port_packet_reorder_buffer #(
	parameter int NUM_PORTS      = 16,
	parameter int SLOTS_PER_PORT = 16,
	parameter int PACKET_BYTES   = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	ppr_req_if.sink   req,
	ppr_rsp_if.source rsp
);

	localparam int PORT_AW = $clog2(NUM_PORTS);
	localparam int SLOT_AW = (SLOTS_PER_PORT > 1) ? $clog2(SLOTS_PER_PORT) : 1;
	localparam int PM_W    = SLOTS_PER_PORT + 1 + ppr_pkg::NUM_W;
	localparam int SM_W    = ppr_pkg::NUM_W + ppr_pkg::HANDLE_W;
	localparam int SM_AW   = PORT_AW + SLOT_AW;

	logic               pm_we;
	logic [PORT_AW-1:0] pm_waddr;
	logic [PM_W-1:0]    pm_wdata;
	logic [PORT_AW-1:0] pm_raddr;
	logic [PM_W-1:0]    pm_rdata;

	logic               sm_we;
	logic [SM_AW-1:0]   sm_waddr;
	logic [SM_W-1:0]    sm_wdata;
	logic [SM_AW-1:0]   sm_raddr;
	logic [SM_W-1:0]    sm_rdata;

	logic               push_valid;
	logic               push_ready;
	ppr_pkg::out_item_t push_data;

	ppr_ram #(
		.WIDTH(PM_W),
		.DEPTH(NUM_PORTS)
	) u_port_mem (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (pm_wdata),
		.raddr (pm_raddr),
		.rdata (pm_rdata)
	);

	ppr_ram #(
		.WIDTH(SM_W),
		.DEPTH(NUM_PORTS * (2 ** SLOT_AW))
	) u_slot_mem (
		.clk   (clk),
		.we    (sm_we),
		.waddr (sm_waddr),
		.wdata (sm_wdata),
		.raddr (sm_raddr),
		.rdata (sm_rdata)
	);

	ppr_engine #(
		.NUM_PORTS      (NUM_PORTS),
		.SLOTS_PER_PORT (SLOTS_PER_PORT),
		.PACKET_BYTES   (PACKET_BYTES)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.pm_we      (pm_we),
		.pm_waddr   (pm_waddr),
		.pm_wdata   (pm_wdata),
		.pm_raddr   (pm_raddr),
		.pm_rdata   (pm_rdata),
		.sm_we      (sm_we),
		.sm_waddr   (sm_waddr),
		.sm_wdata   (sm_wdata),
		.sm_raddr   (sm_raddr),
		.sm_rdata   (sm_rdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ppr_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.rsp        (rsp)
	);

endmodule
